[hdl/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/ubi_pkg.sv]
package ubi_pkg;
  localparam int unsigned Rows = 4096;
  localparam int unsigned Card = 64;
  localparam int unsigned RowW = $clog2(Rows);
  localparam int unsigned CntW = RowW + 1;
  localparam int unsigned ValW = 6;
  localparam int unsigned TallyW = 13;
  localparam logic [TallyW-1:0] TallyMax = 13'd8191;

  localparam logic [2:0] ReqAppend = 3'd0;
  localparam logic [2:0] ReqUpdate = 3'd1;
  localparam logic [2:0] ReqRemove = 3'd2;
  localparam logic [2:0] ReqEval   = 3'd3;
  localparam logic [2:0] ReqRange  = 3'd4;
  localparam logic [2:0] ReqLookup = 3'd5;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StNoop = 2'd1;
  localparam logic [1:0] StErr  = 2'd2;

  localparam logic [0:0] CfgThresh = 1'b0;
  localparam logic [0:0] CfgCard   = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] row_id;
    logic [5:0]  val_code;
    logic [6:0]  span;
  } req_t;

  typedef struct packed {
    logic [12:0] tally;
    logic [5:0]  found_value;
    logic        value_valid;
    logic [1:0]  status;
  } rsp_t;
endpackage

[hdl/ubi_req_if.sv]
interface ubi_req_if;
  import ubi_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/ubi_rsp_if.sv]
interface ubi_rsp_if;
  import ubi_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/ubi_ram.sv]
module ubi_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hdl/updatable_bitmap_index_top.sv]
// Updatable bitmap index over 4096 rows and 64 values.
// Channels: req (sink) carries one request item; rsp (source) returns one
// result item per request. Configuration is a plain write port: cfg_we_i,
// cfg_idx_i (0 merge threshold, 1 values in use), cfg_wdata_i.
// Base and update bitmaps live in two 64x4096 single-port-read RAMs.
// After reset the block runs a clearing pass over both RAMs
// and takes no request until it ends.
// Append, update and remove read the row, modify it and write it back;
// lookup only reads it. Evaluate walks all rows once to count and, when
// it merges, walks them a second time. Range walks all rows once. The row
// walk, one RAM read per cycle, sets the rate. One item is worked at a time.
// The result sits in an output register until taken; while the receiver
// stalls, the next request is not accepted.
module updatable_bitmap_index_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,
  ubi_req_if.sink     req,
  ubi_rsp_if.source   rsp
);
  import ubi_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_WAIT, S_ROW, S_SCAN, S_MERGE, S_OUT
  } state_e;

  state_e            state_q;
  req_t              req_q;
  rsp_t              rsp_q;
  logic [12:0]       thresh_q;
  logic [6:0]        vin_q;
  logic [CntW-1:0]   fill_q;
  logic [RowW-1:0]   addr_q;
  logic [RowW-1:0]   wbk_q;
  logic              rvld_q;
  logic              rlast_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   n_q;
  logic [63:0]       mask_q;

  logic              we_b, we_d2;
  logic [RowW-1:0]   waddr;
  logic [63:0]       wb, wd, rb, rd;
  logic [RowW-1:0]   raddr;
  logic [6:0]        card;
  logic [63:0]       live;
  logic [5:0]        cur;
  logic              cur_ok;
  logic [7:0]        rng_end;
  logic [63:0]       vmask;

  assign card = (vin_q < 7'd64) ? vin_q : 7'd64;
  assign live = rb ^ rd;
  assign vmask = 64'd1 << req_q.val_code;
  assign rng_end = {2'b0, req_q.val_code} + {1'b0, req_q.span};

  always_comb begin
    cur = '0;
    cur_ok = 1'b0;
    for (int i = Card - 1; i >= 0; i--) begin
      if (live[i] && (7'(i) < card)) begin
        cur = 6'(i);
        cur_ok = 1'b1;
      end
    end
  end

  assign raddr = (state_q == S_IDLE) ? req.data.row_id[RowW-1:0] : addr_q;

  always_comb begin
    we_b = 1'b0;
    we_d2 = 1'b0;
    waddr = wbk_q;
    wb = rb;
    wd = rd;
    case (state_q)
      S_CLEAR: begin
        we_b = 1'b1;
        we_d2 = 1'b1;
        waddr = addr_q;
        wb = '0;
        wd = '0;
      end
      S_ROW: begin
        case (req_q.req_type)
          ReqAppend: begin
            we_b = 1'b1;
            wb = rb | vmask;
          end
          ReqUpdate: begin
            we_d2 = cur_ok && (cur != req_q.val_code);
            wd = rd ^ vmask ^ (64'd1 << cur);
          end
          ReqRemove: begin
            we_d2 = cur_ok;
            wd = rd ^ (64'd1 << cur);
          end
          default: ;
        endcase
      end
      S_MERGE: begin
        we_b = rvld_q;
        we_d2 = rvld_q;
        wb = rb ^ (rd & mask_q);
        wd = rd & ~mask_q;
      end
      default: ;
    endcase
  end

  ubi_ram #(.Width(64), .Depth(Rows)) u_base (
    .clk_i(clk_i), .we_i(we_b), .waddr_i(waddr), .wdata_i(wb),
    .raddr_i(raddr), .rdata_o(rb));
  ubi_ram #(.Width(64), .Depth(Rows)) u_delta (
    .clk_i(clk_i), .we_i(we_d2), .waddr_i(waddr), .wdata_i(wd),
    .raddr_i(raddr), .rdata_o(rd));

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = (state_q == S_OUT);
  assign rsp.data = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 13'd16;
      vin_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThresh: thresh_q <= cfg_wdata_i;
        CfgCard:   vin_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q <= '0;
      fill_q <= '0;
      rvld_q <= 1'b0;
      rlast_q <= 1'b0;
      cnt_q <= '0;
      n_q <= '0;
      wbk_q <= '0;
      mask_q <= '0;
      req_q <= '0;
      rsp_q <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == RowW'(Rows - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            req_q <= req.data;
            rsp_q <= '0;
            addr_q <= req.data.row_id[RowW-1:0];
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_OUT;
          case (req_q.req_type)
            ReqAppend: begin
              if (fill_q >= CntW'(Rows) || {1'b0, req_q.val_code} >= card) begin
                rsp_q.status <= StErr;
              end else begin
                addr_q <= fill_q[RowW-1:0];
                wbk_q <= fill_q[RowW-1:0];
                fill_q <= fill_q + 1'b1;
                state_q <= S_WAIT;
              end
            end
            ReqUpdate: begin
              if ({1'b0, req_q.val_code} >= card) rsp_q.status <= StErr;
              else begin
                wbk_q <= addr_q;
                state_q <= S_ROW;
              end
            end
            ReqRemove, ReqLookup: begin
              wbk_q <= addr_q;
              state_q <= S_ROW;
            end
            ReqEval: begin
              if ({1'b0, req_q.val_code} >= card) rsp_q.status <= StErr;
              else begin
                mask_q <= vmask;
                addr_q <= '0;
                cnt_q <= '0;
                n_q <= '0;
                rvld_q <= 1'b0;
                rlast_q <= 1'b0;
                state_q <= S_SCAN;
              end
            end
            ReqRange: begin
              if (rng_end > {1'b0, card}) rsp_q.status <= StErr;
              else if (req_q.span != 7'd0) begin
                mask_q <= (req_q.span >= 7'd64) ? '1
                        : (((64'd1 << req_q.span) - 64'd1) << req_q.val_code);
                addr_q <= '0;
                n_q <= '0;
                rvld_q <= 1'b0;
                rlast_q <= 1'b0;
                state_q <= S_SCAN;
              end
            end
            default: rsp_q.status <= StNoop;
          endcase
        end
        S_WAIT: state_q <= S_ROW;
        S_ROW: begin
          state_q <= S_OUT;
          case (req_q.req_type)
            ReqUpdate: begin
              if (!cur_ok || cur == req_q.val_code) rsp_q.status <= StNoop;
            end
            ReqRemove: begin
              if (!cur_ok) rsp_q.status <= StNoop;
            end
            ReqLookup: begin
              rsp_q.found_value <= cur_ok ? cur : 6'd0;
              rsp_q.value_valid <= cur_ok;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          rvld_q <= !rlast_q;
          if (!rlast_q) begin
            addr_q <= addr_q + 1'b1;
            rlast_q <= (addr_q == RowW'(Rows - 1));
          end
          if (rvld_q) begin
            if (req_q.req_type == ReqEval) begin
              if ((rd & mask_q) != '0) cnt_q <= cnt_q + 1'b1;
              if ((live & mask_q) != '0) n_q <= n_q + 1'b1;
            end else if ((rb & mask_q) != '0) begin
              n_q <= n_q + 1'b1;
            end
          end
          if (rlast_q && rvld_q) begin
            rsp_q.tally <= (n_q + CntW'((req_q.req_type == ReqEval)
              ? ((live & mask_q) != '0) : ((rb & mask_q) != '0)));
            state_q <= S_OUT;
            if (req_q.req_type == ReqEval && (CntW'(cnt_q + CntW'((rd & mask_q) != '0))
                > CntW'(thresh_q))) begin
              addr_q <= '0;
              wbk_q <= '0;
              rvld_q <= 1'b0;
              rlast_q <= 1'b0;
              state_q <= S_MERGE;
            end
          end
        end
        S_MERGE: begin
          rvld_q <= !rlast_q;
          if (!rlast_q) begin
            addr_q <= addr_q + 1'b1;
            rlast_q <= (addr_q == RowW'(Rows - 1));
          end
          if (rvld_q) wbk_q <= wbk_q + 1'b1;
          if (rlast_q && rvld_q) state_q <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CntW'(Rows))
  `ASSERT_IMPL(a_no_write_idle, state_q == S_IDLE, !we_b && !we_d2)
  `ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_q == S_READ)
  `ASSERT_NEXT(a_rsp_holds, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
endmodule
